// ----- rtl/fkr_pkg.sv -----
// Shared types and constants for the FIFO queue with keyed removal.
// Used by fkr_mem, fkr_ctrl and fifo_with_keyed_removal_core.
package fkr_pkg;

    localparam int FKR_DEPTH = 16;

    localparam int W_FUNC   = 2;
    localparam int W_HANDLE = 16;
    localparam int W_KEY    = 32;

    localparam logic [W_FUNC-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [W_FUNC-1:0] FUNC_SHIFT  = 2'd1;
    localparam logic [W_FUNC-1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic [W_HANDLE-1:0] handle;
        logic [W_KEY-1:0]    key;
    } t_entry;

endpackage

// ----- rtl/fkr_mem.sv -----
// Entry storage: one write port, one read port, registered read data.
// Depends on fkr_pkg for the entry type.
module fkr_mem #(
    parameter int DEPTH = fkr_pkg::FKR_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  fkr_pkg::t_entry              i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output fkr_pkg::t_entry              o_rdata
);
    import fkr_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fkr_ctrl.sv -----
// Sequencer for push, shift and remove-by-key over the entry memory.
// Depends on fkr_pkg; drives the ports of fkr_mem.
module fkr_ctrl #(
    parameter int DEPTH = fkr_pkg::FKR_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fkr_pkg::W_FUNC-1:0]       i_func,
    input  logic [fkr_pkg::W_HANDLE-1:0]     i_handle,
    input  logic [fkr_pkg::W_KEY-1:0]        i_key,
    output logic                             o_busy,
    output logic                             o_strobe,
    output logic [fkr_pkg::W_HANDLE-1:0]     o_handle,
    output logic                             o_valid,
    output logic                             o_removed,
    output logic                             o_overflow,
    output logic [$clog2(DEPTH+1)-1:0]       o_count,
    output logic                             o_we,
    output logic [$clog2(DEPTH)-1:0]         o_waddr,
    output fkr_pkg::t_entry                  o_wdata,
    output logic [$clog2(DEPTH)-1:0]         o_raddr,
    input  fkr_pkg::t_entry                  i_rdata
);
    import fkr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SHIFT   = 4'b0010,
        S_SCAN    = 4'b0100,
        S_COMPACT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [W_KEY-1:0]    r_key, n_key;
    logic [AW-1:0]       r_ridx, n_ridx;
    logic                r_strobe, n_strobe;
    logic [W_HANDLE-1:0] r_handle, n_handle;
    logic                r_valid, n_valid;
    logic                r_removed, n_removed;
    logic                r_overflow, n_overflow;
    logic                last_entry;

    // Ring position of an offset from the head; both inputs stay below DEPTH.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    // The entry read last cycle is the youngest one held.
    assign last_entry = ((CW'(r_ridx) + CW'(1)) == r_count);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_key      = r_key;
        n_ridx     = r_ridx;
        n_strobe   = 1'b0;
        n_handle   = '0;
        n_valid    = 1'b0;
        n_removed  = 1'b0;
        n_overflow = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_head;
        o_wdata    = i_rdata;
        o_raddr    = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key = i_key;
                    case (i_func)
                        FUNC_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count == DEPTH_C) begin
                                n_overflow = 1'b1;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = slot(r_head, r_count[AW-1:0]);
                                o_wdata = '{handle: i_handle, key: i_key};
                                n_count = r_count + CW'(1);
                            end
                        end
                        FUNC_SHIFT: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                o_raddr = r_head;
                                n_head  = slot(r_head, AW'(1));
                                n_count = r_count - CW'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                o_raddr = r_head;
                                n_ridx  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                n_strobe = 1'b1;
                n_valid  = 1'b1;
                n_handle = i_rdata.handle;
                n_state  = S_IDLE;
            end

            // Compare the entry read last cycle, read the next one meanwhile.
            S_SCAN: begin
                if (i_rdata.key == r_key) begin
                    if (last_entry) begin
                        n_count   = r_count - CW'(1);
                        n_strobe  = 1'b1;
                        n_removed = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        o_raddr = slot(r_head, r_ridx + AW'(1));
                        n_ridx  = r_ridx + AW'(1);
                        n_state = S_COMPACT;
                    end
                end else if (last_entry) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_raddr = slot(r_head, r_ridx + AW'(1));
                    n_ridx  = r_ridx + AW'(1);
                end
            end

            // Move each younger entry down by one slot, one per cycle.
            S_COMPACT: begin
                o_we    = 1'b1;
                o_waddr = slot(r_head, r_ridx - AW'(1));
                o_wdata = i_rdata;
                if (last_entry) begin
                    n_count   = r_count - CW'(1);
                    n_strobe  = 1'b1;
                    n_removed = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_raddr = slot(r_head, r_ridx + AW'(1));
                    n_ridx  = r_ridx + AW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_valid    <= 1'b0;
            r_removed  <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_strobe   <= n_strobe;
            r_valid    <= n_valid;
            r_removed  <= n_removed;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_ridx   <= n_ridx;
        r_handle <= n_handle;
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_handle   = r_handle;
    assign o_valid    = r_valid;
    assign o_removed  = r_removed;
    assign o_overflow = r_overflow;
    assign o_count    = r_count;

endmodule

// ----- rtl/fifo_with_keyed_removal_core.sv -----
// FIFO queue of waiter entries with removal by owner key.
// Result strobe: push and unused codes strobe in the cycle after acceptance, shift after
// S_SHIFT, remove after scanning every held entry (one memory read per entry scanned,
// then one read and one write per entry moved). busy is low again in the strobe cycle.
// Reset (synchronous, active low) empties the queue; entry memory is not cleared.
module fifo_with_keyed_removal_core #(
    parameter int DEPTH = fkr_pkg::FKR_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fkr_pkg::W_FUNC-1:0]     i_func,
    input  logic [fkr_pkg::W_HANDLE-1:0]   i_waiter_handle,
    input  logic [fkr_pkg::W_KEY-1:0]      i_owner_key,
    output logic                           o_strobe,
    output logic [fkr_pkg::W_HANDLE-1:0]   o_out_handle,
    output logic                           o_out_valid,
    output logic                           o_removed,
    output logic                           o_overflow,
    output logic [$clog2(DEPTH+1)-1:0]     o_entry_count
);
    import fkr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    fkr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_func     (i_func),
        .i_handle   (i_waiter_handle),
        .i_key      (i_owner_key),
        .o_busy     (busy),
        .o_strobe   (o_strobe),
        .o_handle   (o_out_handle),
        .o_valid    (o_out_valid),
        .o_removed  (o_removed),
        .o_overflow (o_overflow),
        .o_count    (o_entry_count),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_raddr    (mem_raddr),
        .i_rdata    (mem_rdata)
    );

    fkr_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_overflow) |-> (o_entry_count == CW'(DEPTH)))
        else $error("overflow flagged while queue not full");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_PUSH && o_entry_count != CW'(DEPTH))
        |=> (o_strobe && !o_overflow
             && o_entry_count == $past(o_entry_count) + CW'(1)))
        else $error("push into non-full queue did not add one entry");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_out_valid, o_removed, o_overflow}))
        else $error("more than one result flag set");

    a_flags_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> (!o_out_valid && !o_removed && !o_overflow))
        else $error("result flag set outside strobe");
`endif

endmodule
